// File: design/pnscd_pkg.sv
// shared types and constants for the poisson nmf coordinate descent weight solver
// no dependencies
package pnscd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // store sizes, fixed by the 8 bit row and 4 bit column fields
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 16;

  typedef enum logic [1:0] {
    ACT_LOAD_ENTRY  = 2'd0,
    ACT_LOAD_ROW_W  = 2'd1,
    ACT_LOAD_COL    = 2'd2,
    ACT_RUN         = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CFG_PASS_COUNT  = 3'd0,
    CFG_EPSILON     = 3'd1,
    CFG_ROWS        = 3'd2,
    CFG_COLS        = 3'd3,
    CFG_GIVEN_SUM   = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT,
    ST_FIT_STORE,
    ST_SCAN,
    ST_GRAD,
    ST_DIV_X,
    ST_UPDATE,
    ST_NEXT_COL,
    ST_EMIT
  } state_t;

  // per-phase operations the controller asks of the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIT,
    OP_SCAN,
    OP_GRAD,
    OP_DIVX,
    OP_UPD,
    OP_EMIT
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic first;    // first row step of a phase (clears accumulators)
    logic step;     // advance one row / column step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phase_done;
  } stat_t;

  // saturate a 64 bit value to 32 bits
  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? ALL_ONES : v[31:0];
  endfunction

endpackage

// File: design/pnscd_divider.sv
// restoring divider, one quotient bit per cycle, 32 bit saturated result
// depends on pnscd_pkg
module pnscd_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] num,
  input  logic [33:0] den,
  output logic        done,
  output logic [31:0] quot
);
  localparam int NW = 34 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dividend;
  logic [NW-1:0] q;
  logic [34:0]   rem;
  logic [33:0]   dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          zero_den;
  logic [34:0]   trial;
  logic [34:0]   rem_next;

  // shift in next dividend bit and try subtract
  always_comb begin
    trial = {rem[33:0], dividend[NW-1]};
    rem_next = trial;
    if (trial >= {1'b0, dsr}) begin
      rem_next = trial - {1'b0, dsr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= (den != 34'd0);
        done     <= (den == 34'd0);
        zero_den <= (den == 34'd0);
        dividend <= {num, {FRAC_BITS{1'b0}}};
        dsr      <= den;
        rem      <= '0;
        q        <= '0;
        cnt      <= CW'(NW);
        quot     <= (num != 34'd0) ? pnscd_pkg::ALL_ONES : 32'd0;
      end else if (busy) begin
        rem      <= rem_next;
        dividend <= {dividend[NW-2:0], 1'b0};
        q        <= {q[NW-2:0], (trial >= {1'b0, dsr})};
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (done && !zero_den) begin
        quot <= quot;
      end
      if (busy && cnt == CW'(1)) begin
        quot <= pnscd_pkg::sat32(64'({q[NW-2:0], (trial >= {1'b0, dsr})}));
      end
    end
  end
endmodule

// File: design/pnscd_datapath.sv
// datapath: stores, multiply chain, accumulators, divider and row/column counters
// depends on pnscd_pkg and pnscd_divider
module pnscd_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pnscd_pkg::cmd_t      cmd,
  output pnscd_pkg::stat_t     stat,
  // loads
  input  logic                 ld_entry,
  input  logic                 ld_row_w,
  input  logic                 ld_col,
  input  logic [7:0]           row_index,
  input  logic [3:0]           col_index,
  input  logic [31:0]          value,
  input  logic [31:0]          col_sum,
  // config
  input  logic [15:0]          epsilon,
  input  logic [8:0]           rows_in_use,
  input  logic [4:0]           cols_in_use,
  input  logic                 use_given_colsum,
  // results
  output logic                 res_valid,
  output logic [3:0]           out_col,
  output logic [31:0]          out_weight,
  output logic                 last
);
  localparam int MAX_ROWS = pnscd_pkg::MAX_ROWS;
  localparam int MAX_COLS = pnscd_pkg::MAX_COLS;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CWI = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RC = $clog2(MAX_ROWS + 1);
  localparam int CC = $clog2(MAX_COLS + 1);

  // memories
  logic [31:0] mat_mem [MAX_ROWS*MAX_COLS];
  logic [31:0] roww_mem [MAX_ROWS];
  logic [31:0] fit_mem [MAX_ROWS];
  logic [31:0] mix_w [MAX_COLS];
  logic [31:0] gsum [MAX_COLS];

  // clamped sizes
  logic [RC-1:0] nr;
  logic [CC-1:0] nc;
  always_comb begin
    if (rows_in_use == 9'd0) nr = RC'(1);
    else if (32'(rows_in_use) > MAX_ROWS) nr = RC'(MAX_ROWS);
    else nr = RC'(rows_in_use);
    if (cols_in_use == 5'd0) nc = CC'(1);
    else if (32'(cols_in_use) > MAX_COLS) nc = CC'(MAX_COLS);
    else nc = CC'(cols_in_use);
  end

  // counters
  logic [RC-1:0] row_ctr;
  logic [CC-1:0] col_ctr;
  logic [RC-1:0] r_idx;   // row of current step
  logic [CC-1:0] c_idx;   // column of current step
  logic [CC-1:0] jcol;    // column being optimized

  // sub-step sequencing inside one row step
  logic [2:0] sub;
  logic       div_start, div_done;
  logic [33:0] div_num, div_den;
  logic [31:0] div_q;

  pnscd_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    qmul = pnscd_pkg::sat32(p >> FRAC_BITS);
  endfunction

  function automatic logic [31:0] sadd(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {1'b0, b};
    sadd = t[32] ? pnscd_pkg::ALL_ONES : t[31:0];
  endfunction

  // registered memory reads
  logic [31:0] l_rd, w_rd, f_rd;
  logic [31:0] acc, h_acc, s_acc, csum_acc, r_reg, rr_reg, xold, xnew, tmp;
  logic [33:0] gpos;
  logic        gneg;
  logic [31:0] p1;

  logic [RW-1:0] rd_row;
  logic [CWI-1:0] rd_col;
  assign rd_row = r_idx[RW-1:0];
  assign rd_col = (cmd.op == pnscd_pkg::OP_FIT) ? c_idx[CWI-1:0] : jcol[CWI-1:0];

  // stores: loads and memory reads
  always_ff @(posedge clk) begin
    if (ld_entry && 32'(row_index) < MAX_ROWS && 32'(col_index) < MAX_COLS) begin
      mat_mem[{RW'(row_index), CWI'(col_index)}] <= value;
    end
    if (ld_row_w && 32'(row_index) < MAX_ROWS) begin
      roww_mem[RW'(row_index)] <= value;
    end
    l_rd <= mat_mem[{rd_row, rd_col}];
    w_rd <= roww_mem[rd_row];
    f_rd <= fit_mem[rd_row];
  end

  logic fit_wr, upd_wr;
  logic [31:0] fit_wdata;
  always_ff @(posedge clk) begin
    if (fit_wr || upd_wr) begin
      fit_mem[rd_row] <= fit_wdata;
    end
  end

  // row-step sequencing: sub 0 issue read, sub 1 data valid, later subs compute
  assign p1 = qmul(l_rd, mix_w[rd_col]);

  always_comb begin
    fit_wr    = 1'b0;
    upd_wr    = 1'b0;
    fit_wdata = acc;
    div_start = 1'b0;
    div_num   = {2'b0, l_rd};
    div_den   = {1'b0, f_rd} + 34'(epsilon);
    case (cmd.op)
      pnscd_pkg::OP_FIT: begin
        if (sub == 3'd2) begin
          if (c_idx == nc - CC'(1)) begin
            fit_wr = 1'b1;
            fit_wdata = sadd(acc, p1);
          end
        end
      end
      pnscd_pkg::OP_SCAN: begin
        if (sub == 3'd1) div_start = 1'b1;
      end
      pnscd_pkg::OP_GRAD: begin
        div_num = gpos;
        div_den = {2'b0, h_acc} + 34'(epsilon);
        if (sub == 3'd2) div_start = !gneg;
      end
      pnscd_pkg::OP_UPD: begin
        if (sub == 3'd3) begin
          upd_wr = 1'b1;
          if (xnew >= xold) fit_wdata = sadd(f_rd, tmp);
          else fit_wdata = (tmp > f_rd) ? 32'd0 : f_rd - tmp;
        end
      end
      default: ;
    endcase
  end

  logic last_row, last_col_step;
  assign last_row = (r_idx == nr - RC'(1));
  assign last_col_step = (c_idx == nc - CC'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
      r_idx <= '0;
      c_idx <= '0;
      jcol <= '0;
      stat <= '0;
      res_valid <= 1'b0;
    end else begin
      stat.phase_done <= 1'b0;
      res_valid <= 1'b0;
      if (ld_col && 32'(col_index) < MAX_COLS) begin
        mix_w[CWI'(col_index)] <= value;
        gsum[CWI'(col_index)] <= col_sum;
      end
      if (cmd.first) begin
        sub <= '0;
        r_idx <= '0;
        c_idx <= '0;
        acc <= '0;
        h_acc <= '0;
        s_acc <= '0;
        csum_acc <= '0;
        if (cmd.op == pnscd_pkg::OP_SCAN || cmd.op == pnscd_pkg::OP_EMIT) jcol <= '0;
      end else if (stat.phase_done) begin
        // phase finished: rewind row sequencing for the next phase
        sub <= '0;
        r_idx <= '0;
        c_idx <= '0;
        if (cmd.op == pnscd_pkg::OP_FIT) jcol <= '0;
      end else begin
        case (cmd.op)
          pnscd_pkg::OP_FIT: begin
            sub <= sub + 3'd1;
            if (sub == 3'd2) begin
              sub <= '0;
              acc <= sadd(acc, p1);
              if (last_col_step) begin
                acc <= '0;
                c_idx <= '0;
                r_idx <= r_idx + RC'(1);
                if (last_row) stat.phase_done <= 1'b1;
              end else begin
                c_idx <= c_idx + CC'(1);
              end
            end
          end
          pnscd_pkg::OP_SCAN: begin
            if (sub != 3'd2) sub <= sub + 3'd1;
            else if (div_done) sub <= 3'd3;
            if (sub == 3'd3) begin
              r_reg <= div_q;
              rr_reg <= qmul(div_q, div_q);
            end
            if (sub == 3'd4) begin
              rr_reg <= qmul(w_rd, rr_reg);
              tmp <= qmul(w_rd, r_reg);
            end
            if (sub == 3'd5) begin
              sub <= '0;
              h_acc <= sadd(h_acc, rr_reg);
              s_acc <= sadd(s_acc, tmp);
              csum_acc <= sadd(csum_acc, l_rd);
              r_idx <= r_idx + RC'(1);
              if (last_row) stat.phase_done <= 1'b1;
            end
          end
          pnscd_pkg::OP_GRAD: begin
            if (sub == 3'd0) begin
              xold <= mix_w[jcol[CWI-1:0]];
              tmp <= qmul(h_acc, mix_w[jcol[CWI-1:0]]);
              sub <= 3'd1;
            end else if (sub == 3'd1) begin
              begin : g_blk
                logic [33:0] pos;
                logic [31:0] u;
                u = use_given_colsum ? gsum[jcol[CWI-1:0]] : csum_acc;
                pos = {2'b0, s_acc} + {2'b0, tmp};
                gneg <= (pos <= {2'b0, u});
                gpos <= pos - {2'b0, u};
              end
              sub <= 3'd2;
            end else if (sub == 3'd2) begin
              if (gneg) begin
                xnew <= '0;
                stat.phase_done <= 1'b1;
              end
              sub <= 3'd3;
            end else if (div_done) begin
              xnew <= div_q;
              stat.phase_done <= 1'b1;
            end
          end
          pnscd_pkg::OP_UPD: begin
            sub <= sub + 3'd1;
            if (sub == 3'd2) begin
              tmp <= qmul((xnew >= xold) ? xnew - xold : xold - xnew, l_rd);
            end
            if (sub == 3'd3) begin
              sub <= '0;
              r_idx <= r_idx + RC'(1);
              if (last_row) begin
                stat.phase_done <= 1'b1;
                mix_w[jcol[CWI-1:0]] <= xnew;
              end
            end
          end
          pnscd_pkg::OP_DIVX: begin
            // advance column
            if (cmd.step) begin
              sub <= '0;
              r_idx <= '0;
              h_acc <= '0;
              s_acc <= '0;
              csum_acc <= '0;
              if (jcol == nc - CC'(1)) begin
                jcol <= '0;
                stat.phase_done <= 1'b1;
              end else begin
                jcol <= jcol + CC'(1);
              end
            end
          end
          pnscd_pkg::OP_EMIT: begin
            if (cmd.step) begin
              res_valid <= 1'b1;
              out_col <= 4'(jcol);
              out_weight <= mix_w[jcol[CWI-1:0]];
              last <= (jcol == nc - CC'(1));
              jcol <= jcol + CC'(1);
              if (jcol == nc - CC'(1)) stat.phase_done <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// File: design/pnscd_ctrl.sv
// controller state machine sequencing fit, passes, column steps and result output
// depends on pnscd_pkg
module pnscd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              run,
  input  logic [7:0]        pass_count,
  input  pnscd_pkg::stat_t  stat,
  output pnscd_pkg::cmd_t   cmd,
  output logic              busy
);
  pnscd_pkg::state_t state, state_next;
  logic [7:0] pass_left, pass_left_next;
  logic       entered, entered_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnscd_pkg::ST_IDLE;
      pass_left <= '0;
      entered <= 1'b0;
    end else begin
      state <= state_next;
      pass_left <= pass_left_next;
      entered <= entered_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    pass_left_next = pass_left;
    entered_next = 1'b1;
    case (state)
      pnscd_pkg::ST_IDLE: begin
        entered_next = 1'b0;
        if (run) begin
          state_next = pnscd_pkg::ST_FIT;
          pass_left_next = pass_count;
        end
      end
      pnscd_pkg::ST_FIT: if (entered && stat.phase_done) begin
        entered_next = 1'b0;
        state_next = (pass_left == 8'd0) ? pnscd_pkg::ST_EMIT : pnscd_pkg::ST_SCAN;
      end
      pnscd_pkg::ST_SCAN: if (entered && stat.phase_done) begin
        entered_next = 1'b0;
        state_next = pnscd_pkg::ST_GRAD;
      end
      pnscd_pkg::ST_GRAD: if (entered && stat.phase_done) begin
        entered_next = 1'b0;
        state_next = pnscd_pkg::ST_UPDATE;
      end
      pnscd_pkg::ST_UPDATE: if (entered && stat.phase_done) begin
        entered_next = 1'b0;
        state_next = pnscd_pkg::ST_NEXT_COL;
      end
      pnscd_pkg::ST_NEXT_COL: begin
        entered_next = 1'b0;
        state_next = pnscd_pkg::ST_DIV_X;
      end
      pnscd_pkg::ST_DIV_X: begin
        // wait for the registered column advance to report wrap
        if (stat.phase_done) begin
          entered_next = 1'b0;
          pass_left_next = pass_left - 8'd1;
          state_next = (pass_left == 8'd1) ? pnscd_pkg::ST_EMIT : pnscd_pkg::ST_SCAN;
        end else if (entered) begin
          entered_next = 1'b0;
          state_next = pnscd_pkg::ST_SCAN;
        end
      end
      pnscd_pkg::ST_EMIT: if (entered && stat.phase_done) begin
        entered_next = 1'b0;
        state_next = pnscd_pkg::ST_IDLE;
      end
      default: state_next = pnscd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = (state != pnscd_pkg::ST_IDLE);
    cmd.first = !entered;
    case (state)
      pnscd_pkg::ST_IDLE: cmd.first = 1'b0;
      pnscd_pkg::ST_FIT: cmd.op = pnscd_pkg::OP_FIT;
      pnscd_pkg::ST_SCAN: begin
        cmd.op = pnscd_pkg::OP_SCAN;
        cmd.first = 1'b0;
      end
      pnscd_pkg::ST_GRAD: begin
        cmd.op = pnscd_pkg::OP_GRAD;
        cmd.first = 1'b0;
      end
      pnscd_pkg::ST_UPDATE: cmd.op = pnscd_pkg::OP_UPD;
      pnscd_pkg::ST_NEXT_COL: begin
        cmd.op = pnscd_pkg::OP_DIVX;
        cmd.first = 1'b0;
        cmd.step = 1'b1;
      end
      pnscd_pkg::ST_DIV_X: begin
        cmd.op = pnscd_pkg::OP_DIVX;
        cmd.first = 1'b0;
      end
      pnscd_pkg::ST_EMIT: begin
        cmd.op = pnscd_pkg::OP_EMIT;
        cmd.step = entered && !stat.phase_done;
      end
      default: ;
    endcase
  end
endmodule

// File: design/poisson_nmf_scd_weight_update.sv
// poisson nmf coordinate descent weight solver, top level
// loads are accepted one per cycle while not busy; a run holds busy through the fit, then,
// per pass and column, the scan (each row step uses the bit-serial divider), the gradient
// divide when the gradient term is positive, and the update, then one result per column
// on consecutive cycles; the receiver cannot stall
// rst is synchronous and active high; it restores register defaults, stores stay undefined
module poisson_nmf_scd_weight_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  row_index,
  input  logic [3:0]  col_index,
  input  logic [31:0] value,
  input  logic [31:0] col_sum,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [3:0]  out_col,
  output logic [31:0] out_weight,
  output logic        last
);
  logic [7:0]  pass_count;
  logic [15:0] epsilon;
  logic [8:0]  rows_in_use;
  logic [4:0]  cols_in_use;
  logic        use_given_colsum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= 8'd1;
      epsilon <= 16'd1;
      rows_in_use <= 9'd256;
      cols_in_use <= 5'd16;
      use_given_colsum <= 1'b0;
    end else if (cfg_we) begin
      case (pnscd_pkg::cfg_index_t'(cfg_index))
        pnscd_pkg::CFG_PASS_COUNT: pass_count <= cfg_data[7:0];
        pnscd_pkg::CFG_EPSILON:    epsilon <= cfg_data;
        pnscd_pkg::CFG_ROWS:       rows_in_use <= cfg_data[8:0];
        pnscd_pkg::CFG_COLS:       cols_in_use <= cfg_data[4:0];
        pnscd_pkg::CFG_GIVEN_SUM:  use_given_colsum <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  pnscd_pkg::cmd_t  cmd;
  pnscd_pkg::stat_t stat;

  pnscd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .run(accept && action == pnscd_pkg::ACT_RUN),
    .pass_count(pass_count), .stat(stat), .cmd(cmd), .busy(busy)
  );

  pnscd_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .ld_entry(accept && action == pnscd_pkg::ACT_LOAD_ENTRY),
    .ld_row_w(accept && action == pnscd_pkg::ACT_LOAD_ROW_W),
    .ld_col(accept && action == pnscd_pkg::ACT_LOAD_COL),
    .row_index(row_index), .col_index(col_index), .value(value), .col_sum(col_sum),
    .epsilon(epsilon), .rows_in_use(rows_in_use), .cols_in_use(cols_in_use),
    .use_given_colsum(use_given_colsum),
    .res_valid(done), .out_col(out_col), .out_weight(out_weight), .last(last)
  );

  // results only appear while a run is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result outside a run");
  // last result ends the run
  a_last_idle: assert property (@(posedge clk) disable iff (rst) (done && last) |=> !busy)
    else $error("run did not end after last result");
  // an accepted run transaction starts the solver
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && action == pnscd_pkg::ACT_RUN) |=> busy)
    else $error("run transaction did not start the solver");
endmodule

// File: bench/tb_top.sv
// self-checking bench for the poisson nmf coordinate descent weight solver
// depends on design/pnscd_pkg.sv and design/poisson_nmf_scd_weight_update.sv
`timescale 1ns / 1ps

typedef struct {
  logic [3:0]  col;
  logic [31:0] weight;
  logic        last;
} weight_result_t;

// holds a copy of the solver state and the weights a run should return
class weight_scoreboard;
  logic [31:0] mat[4096];
  logic [31:0] row_w[256];
  logic [31:0] mix_w[16];
  logic [31:0] given_sum[16];
  logic [31:0] rate[256];
  int unsigned passes = 1;
  logic [31:0] eps = 1;
  int unsigned rows = 256;
  int unsigned cols = 16;
  bit          given = 0;
  weight_result_t pending_weights[$];
  int mismatches = 0;

  function new();
    foreach (mat[i]) mat[i] = '0;
    foreach (row_w[i]) row_w[i] = '0;
    foreach (rate[i]) rate[i] = '0;
    foreach (mix_w[i]) begin
      mix_w[i] = '0;
      given_sum[i] = '0;
    end
  endfunction

  function logic [31:0] sat(logic [63:0] v);
    return (v[63:32] != 0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b};
    return sat(p >> 16);
  endfunction

  function logic [31:0] qdiv(logic [63:0] num, logic [63:0] den);
    if (den == 0) return (num != 0) ? 32'hFFFF_FFFF : 32'h0;
    return sat((num << 16) / den);
  endfunction

  function void note_config(pnscd_pkg::cfg_index_t idx, logic [15:0] data);
    case (idx)
      pnscd_pkg::CFG_PASS_COUNT: passes = data[7:0];
      pnscd_pkg::CFG_EPSILON:    eps = {16'b0, data};
      pnscd_pkg::CFG_ROWS:       rows = data[8:0];
      pnscd_pkg::CFG_COLS:       cols = data[4:0];
      pnscd_pkg::CFG_GIVEN_SUM:  given = data[0];
      default: ;
    endcase
  endfunction

  // one accepted input transaction
  function void note_input(pnscd_pkg::action_t act, logic [7:0] row, logic [3:0] col,
                           logic [31:0] val, logic [31:0] csum);
    int unsigned nr, nc;
    logic [31:0] acc, s, h, csum_acc, u, hx, xold, xnew, l, r, f, d;
    logic [63:0] top;
    case (act)
      pnscd_pkg::ACT_LOAD_ENTRY: mat[{row, col}] = val;
      pnscd_pkg::ACT_LOAD_ROW_W: row_w[row] = val;
      pnscd_pkg::ACT_LOAD_COL: begin
        mix_w[col] = val;
        given_sum[col] = csum;
      end
      default: begin
        nr = (rows < 1) ? 1 : (rows > 256 ? 256 : rows);
        nc = (cols < 1) ? 1 : (cols > 16 ? 16 : cols);
        // fitted rates from the current weights
        for (int i = 0; i < nr; i++) begin
          acc = 0;
          for (int j = 0; j < nc; j++)
            acc = sat({32'b0, acc} + qmul(mat[i*16+j], mix_w[j]));
          rate[i] = acc;
        end
        for (int p = 0; p < passes; p++) begin
          for (int j = 0; j < nc; j++) begin
            s = 0; h = 0; csum_acc = 0;
            for (int i = 0; i < nr; i++) begin
              l = mat[i*16+j];
              r = qdiv({32'b0, l}, {32'b0, rate[i]} + {32'b0, eps});
              h = sat({32'b0, h} + qmul(row_w[i], qmul(r, r)));
              s = sat({32'b0, s} + qmul(row_w[i], r));
              csum_acc = sat({32'b0, csum_acc} + l);
            end
            u = given ? given_sum[j] : csum_acc;
            xold = mix_w[j];
            hx = qmul(h, xold);
            top = {32'b0, s} + {32'b0, hx};
            // non-positive gradient term clamps the weight to zero
            xnew = (top <= {32'b0, u}) ? 32'h0
                 : qdiv(top - u, {32'b0, h} + {32'b0, eps});
            for (int i = 0; i < nr; i++) begin
              l = mat[i*16+j];
              f = rate[i];
              if (xnew >= xold) f = sat({32'b0, f} + qmul(xnew - xold, l));
              else begin
                d = qmul(xold - xnew, l);
                f = (d > f) ? 32'h0 : f - d;
              end
              rate[i] = f;
            end
            mix_w[j] = xnew;
          end
        end
        for (int j = 0; j < nc; j++)
          pending_weights.push_back('{col: j[3:0], weight: mix_w[j], last: (j + 1 == nc)});
      end
    endcase
  endfunction

  function void check_result(logic [3:0] col, logic [31:0] weight, logic last);
    weight_result_t e;
    if (pending_weights.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result col=%0d weight=%h", col, weight);
      return;
    end
    e = pending_weights.pop_front();
    if (e.col !== col || e.weight !== weight || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp col=%0d w=%h last=%0b, got col=%0d w=%h last=%0b",
                 e.col, e.weight, e.last, col, weight, last);
    end
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  action = '0;
  logic [7:0]  row_index = '0;
  logic [3:0]  col_index = '0;
  logic [31:0] value = '0;
  logic [31:0] col_sum = '0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic [3:0]  out_col;
  logic [31:0] out_weight;
  logic        last;

  weight_scoreboard sb = new();
  bit mat_ok[4096];
  bit row_ok[256];
  bit col_ok[16];
  int unsigned gap_pct = 33;
  int unsigned cur_rows = 256, cur_cols = 16;
  int unsigned quiet_cycles = 0;

  poisson_nmf_scd_weight_update DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .row_index(row_index), .col_index(col_index),
    .value(value), .col_sum(col_sum),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_col(out_col), .out_weight(out_weight), .last(last)
  );

  always #5 clk = ~clk;

  // result checking
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(out_col, out_weight, last);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || done || cfg_we || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h0;
      2: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom_range(32'h0000_4000, 32'h0003_0000);
    endcase
  endfunction

  // one input transaction, with random idle cycles before it
  task automatic send_item(pnscd_pkg::action_t act, logic [7:0] row, logic [3:0] col,
                           logic [31:0] val, logic [31:0] csum);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    action <= act;
    row_index <= row;
    col_index <= col;
    value <= val;
    col_sum <= csum;
    do @(posedge clk); while (busy);
    sb.note_input(act, row, col, val, csum);
    case (act)
      pnscd_pkg::ACT_LOAD_ENTRY: mat_ok[{row, col}] = 1;
      pnscd_pkg::ACT_LOAD_ROW_W: row_ok[row] = 1;
      pnscd_pkg::ACT_LOAD_COL:   col_ok[col] = 1;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (sb.pending_weights.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(pnscd_pkg::cfg_index_t idx, logic [15:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.note_config(idx, data);
  endtask

  task automatic configure(int unsigned p, int unsigned e, int unsigned r,
                           int unsigned c, bit g);
    wait_idle();
    write_reg(pnscd_pkg::CFG_PASS_COUNT, 16'(p));
    write_reg(pnscd_pkg::CFG_EPSILON, 16'(e));
    write_reg(pnscd_pkg::CFG_ROWS, 16'(r));
    write_reg(pnscd_pkg::CFG_COLS, 16'(c));
    write_reg(pnscd_pkg::CFG_GIVEN_SUM, 16'(g));
    @(posedge clk);
    cur_rows = (r[8:0] < 1) ? 1 : (r[8:0] > 256 ? 256 : r[8:0]);
    cur_cols = (c[4:0] < 1) ? 1 : (c[4:0] > 16 ? 16 : c[4:0]);
  endtask

  // load every entry a run will read that was never written, then run
  task automatic run_solver();
    for (int i = 0; i < cur_rows; i++) begin
      if (!row_ok[i]) send_item(pnscd_pkg::ACT_LOAD_ROW_W, 8'(i), 4'd0, pick_value(), $urandom);
      for (int j = 0; j < cur_cols; j++)
        if (!mat_ok[i*16+j])
          send_item(pnscd_pkg::ACT_LOAD_ENTRY, 8'(i), 4'(j), pick_value(), $urandom);
    end
    for (int j = 0; j < cur_cols; j++)
      if (!col_ok[j]) send_item(pnscd_pkg::ACT_LOAD_COL, 8'd0, 4'(j), pick_value(), pick_value());
    send_item(pnscd_pkg::ACT_RUN, 8'($urandom), 4'($urandom), $urandom, $urandom);
  endtask

  initial begin
    int unsigned n_items;
    int unsigned k;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, each action, zero denominators, clamps
    configure(1, 1, 2, 2, 0);
    send_item(pnscd_pkg::ACT_LOAD_ENTRY, 0, 0, 32'hFFFF_FFFF, 32'h0);
    send_item(pnscd_pkg::ACT_LOAD_ENTRY, 0, 1, 32'h0, 32'hFFFF_FFFF);
    send_item(pnscd_pkg::ACT_LOAD_ENTRY, 1, 0, 32'h0001_0000, 32'h0);
    send_item(pnscd_pkg::ACT_LOAD_ENTRY, 1, 1, 32'h0002_8000, 32'h0);
    send_item(pnscd_pkg::ACT_LOAD_ROW_W, 0, 0, 32'hFFFF_FFFF, 32'h0);
    send_item(pnscd_pkg::ACT_LOAD_ROW_W, 1, 0, 32'h0001_0000, 32'h0);
    send_item(pnscd_pkg::ACT_LOAD_COL, 0, 0, 32'h0001_0000, 32'hFFFF_FFFF);
    send_item(pnscd_pkg::ACT_LOAD_COL, 0, 1, 32'h0, 32'h0);
    send_item(pnscd_pkg::ACT_LOAD_ENTRY, 8'hFF, 4'hF, 32'h1234_5678, 32'h0);
    send_item(pnscd_pkg::ACT_RUN, 0, 0, 0, 0);
    run_solver();
    configure(1, 1, 2, 2, 1);
    run_solver();
    configure(0, 1, 2, 2, 0);
    run_solver();
    // zero epsilon with zero rates gives zero denominators
    configure(1, 0, 1, 1, 0);
    send_item(pnscd_pkg::ACT_LOAD_COL, 0, 0, 32'h0, 32'h0);
    run_solver();
    configure(255, 16'hFFFF, 1, 1, 0);
    send_item(pnscd_pkg::ACT_LOAD_COL, 0, 0, 32'h0001_0000, 32'h0);
    run_solver();
    configure(1, 1, 0, 0, 1);
    run_solver();
    configure(1, 1, 1, 31, 0);
    run_solver();
    configure(1, 1, 32, 1, 0);
    run_solver();

    // random phases: mostly small sizes, loads with runs in between
    n_items = 0;
    k = 0;
    while (n_items < 120) begin
      gap_pct = (n_items < 40) ? 33 : (n_items < 80) ? 53 : 0;
      configure($urandom_range(0, 3), (k % 4 == 0) ? 0 : $urandom_range(0, 65535),
                $urandom_range(1, 8), $urandom_range(1, 4), 1'($urandom_range(0, 1)));
      for (int t = 0; t < 25; t++) begin
        if ($urandom_range(0, 99) < 15) run_solver();
        else begin
          case ($urandom_range(0, 2))
            0: send_item(pnscd_pkg::ACT_LOAD_ENTRY,
                         8'(($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, cur_rows - 1)),
                         4'($urandom), pick_value(), $urandom);
            1: send_item(pnscd_pkg::ACT_LOAD_ROW_W,
                         8'(($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, cur_rows - 1)),
                         4'($urandom), pick_value(), $urandom);
            default: send_item(pnscd_pkg::ACT_LOAD_COL, 8'($urandom),
                               4'(($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, cur_cols - 1)),
                               pick_value(), pick_value());
          endcase
        end
        n_items++;
      end
      run_solver();
      n_items++;
      k++;
    end

    wait_idle();
    if (sb.pending_weights.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
